### rtl/pcmi_pkg.sv
package pcmi_pkg;

   // Fixed field widths
   localparam int LIN_BITS       = 30;
   localparam int OUTC_BITS      = 10;
   localparam int CFG_SIZE_BITS  = 11;
   localparam int MASK_BITS      = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;

   // Defaults for the top-level parameters
   localparam int DEF_SIZE_BITS  = 10;
   localparam int DEF_COORD_BITS = 21;

   // Opcodes
   localparam logic OP_TO_LINEAR = 1'b0;
   localparam logic OP_TO_COORD  = 1'b1;

   // Register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SIZE_X   = 2'd0,
      CSR_SIZE_Y   = 2'd1,
      CSR_SIZE_Z   = 2'd2,
      CSR_PERIODIC = 2'd3
   } csr_index_type;

endpackage

### rtl/pcmi_divmod.sv
module pcmi_divmod #(
   parameter int DW = 30,
   parameter int VW = 11,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   input  logic [SW-1:0] side_in,
   output logic          out_valid,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder,
   output logic [SW-1:0] side_out
);

   // One restoring step per stage, quotient bits shift in from the right
   logic          valid_ff [DW];
   logic [VW-1:0] rem_ff   [DW];
   logic [DW-1:0] quo_ff   [DW];
   logic [SW-1:0] side_ff  [DW];

   logic [VW-1:0] rem_in   [DW];
   logic [DW-1:0] quo_in   [DW];

   for (genvar k = 0; k < DW; k++) begin : g_step
      logic [VW-1:0] rem_prev;
      logic [DW-1:0] quo_prev;
      logic [VW:0]   trial;
      logic          fits;

      assign rem_prev = (k == 0) ? '0 : rem_ff[(k == 0) ? 0 : k-1];
      assign quo_prev = (k == 0) ? dividend : quo_ff[(k == 0) ? 0 : k-1];

      // Bring down the next dividend bit and try a subtract
      always_comb begin
         trial     = {rem_prev, quo_prev[DW-1]};
         fits      = (trial >= {1'b0, divisor});
         rem_in[k] = fits ? VW'(trial - {1'b0, divisor}) : VW'(trial);
         quo_in[k] = {quo_prev[DW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
            side_ff[k] <= (k == 0) ? side_in : side_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign out_valid = valid_ff[DW-1];
   assign quotient  = quo_ff[DW-1];
   assign remainder = rem_ff[DW-1];
   assign side_out  = side_ff[DW-1];

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (remainder < divisor))
      else $error("remainder not below divisor");
`endif

endmodule

### rtl/periodic_column_major_index_unit.sv
// Converts between 3-D lattice coordinates and a column-major linear index
// (x fastest). Opcode 0 wraps coordinates on periodic axes by floored modulo
// and returns x + size_x*(y + size_y*z), or valid_res = 0 when a coordinate
// lies outside a non-periodic axis. Opcode 1 splits a linear index into
// coordinates by modulo and division over size_x, size_y, size_z. Sizes of
// 0 act as 1, sizes above 2^SIZE_BITS saturate. The pipeline takes one word
// per cycle unless the output word is held; it has three chained restoring
// dividers of one quotient bit per stage. The user must write sizes and the
// periodic mask only while the pipeline is empty; the block does not enforce it.
module periodic_column_major_index_unit #(
   parameter int SIZE_BITS  = pcmi_pkg::DEF_SIZE_BITS,
   parameter int COORD_BITS = pcmi_pkg::DEF_COORD_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic [COORD_BITS-1:0]                req_in_x,
   input  logic [COORD_BITS-1:0]                req_in_y,
   input  logic [COORD_BITS-1:0]                req_in_z,
   input  logic [pcmi_pkg::LIN_BITS-1:0]        req_in_linear,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pcmi_pkg::LIN_BITS-1:0]        rsp_out_linear,
   output logic [pcmi_pkg::OUTC_BITS-1:0]       rsp_out_x,
   output logic [pcmi_pkg::OUTC_BITS-1:0]       rsp_out_y,
   output logic [pcmi_pkg::OUTC_BITS-1:0]       rsp_out_z,
   output logic                                 rsp_valid_res,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pcmi_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pcmi_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   import pcmi_pkg::*;

   localparam int EW  = SIZE_BITS + 1;
   localparam int AW  = (LIN_BITS > COORD_BITS) ? LIN_BITS : COORD_BITS;
   localparam int BSW = 2 + 3*EW;
   localparam int CSW = 2 + 4*EW;

   function automatic logic [EW-1:0] eff_size(logic [CFG_SIZE_BITS-1:0] s);
      logic [32:0] top;
      logic [EW-1:0] r;
      top = 33'd1 << SIZE_BITS;
      if (s == '0) begin
         r = EW'(1);
      end else if (33'(s) > top) begin
         r = EW'(top);
      end else begin
         r = EW'(s);
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] coord_mag(logic [COORD_BITS-1:0] c);
      logic [COORD_BITS-1:0] m;
      m = c[COORD_BITS-1] ? (~c + 1'b1) : c;
      return AW'(m);
   endfunction

   function automatic logic in_lattice(logic [COORD_BITS-1:0] c, logic [EW-1:0] s);
      return !c[COORD_BITS-1] && (33'(c) < 33'(s));
   endfunction

   // Floored modulo of a negative value from the remainder of its magnitude
   function automatic logic [EW-1:0] wrap_fix(logic [EW-1:0] r, logic neg,
                                              logic [EW-1:0] s);
      return (neg && (r != '0)) ? EW'(s - r) : r;
   endfunction

   function automatic logic [OUTC_BITS-1:0] to_outc(logic [EW-1:0] r);
      logic [31:0] w;
      w = 32'(r);
      return w[OUTC_BITS-1:0];
   endfunction

   // Configuration registers
   logic [CFG_SIZE_BITS-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [MASK_BITS-1:0]     periodic_ff;
   logic [EW-1:0]            sx, sy, sz;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff   <= CFG_SIZE_BITS'(1);
         size_y_ff   <= CFG_SIZE_BITS'(1);
         size_z_ff   <= CFG_SIZE_BITS'(1);
         periodic_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SIZE_X:   size_x_ff   <= csr_data[CFG_SIZE_BITS-1:0];
            CSR_SIZE_Y:   size_y_ff   <= csr_data[CFG_SIZE_BITS-1:0];
            CSR_SIZE_Z:   size_z_ff   <= csr_data[CFG_SIZE_BITS-1:0];
            CSR_PERIODIC: periodic_ff <= csr_data[MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign sx = eff_size(size_x_ff);
   assign sy = eff_size(size_y_ff);
   assign sz = eff_size(size_z_ff);

   // Whole pipeline moves together unless the output word is held
   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Input stage: range check, magnitudes, opcode select
   logic          s0_valid_ff, s0_op_ff, s0_ok_ff;
   logic [2:0]    s0_neg_ff;
   logic [AW-1:0] s0_dx_ff, s0_dy_ff, s0_dz_ff;
   logic          s0_ok_in;
   logic [2:0]    s0_neg_in;

   always_comb begin
      s0_ok_in = (in_lattice(req_in_x, sx) || periodic_ff[0]) &&
                 (in_lattice(req_in_y, sy) || periodic_ff[1]) &&
                 (in_lattice(req_in_z, sz) || periodic_ff[2]);
      s0_neg_in = {req_in_z[COORD_BITS-1], req_in_y[COORD_BITS-1],
                   req_in_x[COORD_BITS-1]};
      if (req_opcode == OP_TO_COORD) begin
         s0_ok_in  = 1'b1;
         s0_neg_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_op_ff  <= req_opcode;
         s0_ok_ff  <= s0_ok_in;
         s0_neg_ff <= s0_neg_in;
         s0_dx_ff  <= (req_opcode == OP_TO_COORD) ? AW'(req_in_linear)
                                                  : coord_mag(req_in_x);
         s0_dy_ff  <= coord_mag(req_in_y);
         s0_dz_ff  <= coord_mag(req_in_z);
      end
   end

   // First division round: three lanes in parallel
   logic          a_valid;
   logic [AW-1:0] a_qx;
   logic [EW-1:0] a_rx, a_ry, a_rz;
   logic [2:0]    a_side_x;
   logic          a_negy, a_negz;

   pcmi_divmod #(.DW(AW), .VW(EW), .SW(3)) u_div_ax (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(s0_valid_ff), .dividend(s0_dx_ff), .divisor(sx),
      .side_in({s0_op_ff, s0_ok_ff, s0_neg_ff[0]}),
      .out_valid(a_valid), .quotient(a_qx), .remainder(a_rx), .side_out(a_side_x)
   );

   pcmi_divmod #(.DW(AW), .VW(EW), .SW(1)) u_div_ay (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(s0_valid_ff), .dividend(s0_dy_ff), .divisor(sy),
      .side_in(s0_neg_ff[1]),
      .out_valid(), .quotient(), .remainder(a_ry), .side_out(a_negy)
   );

   pcmi_divmod #(.DW(AW), .VW(EW), .SW(1)) u_div_az (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(s0_valid_ff), .dividend(s0_dz_ff), .divisor(sz),
      .side_in(s0_neg_ff[2]),
      .out_valid(), .quotient(), .remainder(a_rz), .side_out(a_negz)
   );

   // Wrap stage: turn magnitude remainders into floored modulo
   logic          f_valid_ff, f_op_ff, f_ok_ff;
   logic [AW-1:0] f_q_ff;
   logic [EW-1:0] f_cx_ff, f_cy_ff, f_cz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         f_valid_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_op_ff <= a_side_x[2];
         f_ok_ff <= a_side_x[1];
         f_q_ff  <= a_qx;
         f_cx_ff <= wrap_fix(a_rx, a_side_x[0], sx);
         f_cy_ff <= wrap_fix(a_ry, a_negy, sy);
         f_cz_ff <= wrap_fix(a_rz, a_negz, sz);
      end
   end

   // Second and third division rounds for the index split
   logic           b_valid;
   logic [AW-1:0]  b_q;
   logic [EW-1:0]  b_r;
   logic [BSW-1:0] b_side;

   pcmi_divmod #(.DW(AW), .VW(EW), .SW(BSW)) u_div_b (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(f_valid_ff), .dividend(f_q_ff), .divisor(sy),
      .side_in({f_op_ff, f_ok_ff, f_cx_ff, f_cy_ff, f_cz_ff}),
      .out_valid(b_valid), .quotient(b_q), .remainder(b_r), .side_out(b_side)
   );

   logic           c_valid;
   logic [EW-1:0]  c_r;
   logic [CSW-1:0] c_side;

   pcmi_divmod #(.DW(AW), .VW(EW), .SW(CSW)) u_div_c (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(b_valid), .dividend(b_q), .divisor(sz),
      .side_in({b_side, b_r}),
      .out_valid(c_valid), .quotient(), .remainder(c_r), .side_out(c_side)
   );

   logic          c_op, c_ok;
   logic [EW-1:0] c_cx, c_cy, c_cz, c_ry;
   assign {c_op, c_ok, c_cx, c_cy, c_cz, c_ry} = c_side;

   // Index build, first product: z*size_y + y
   logic [2*EW:0]       t1_full;
   logic                p1_valid_ff, p1_op_ff, p1_ok_ff;
   logic [EW-1:0]       p1_cx_ff, p1_ry_ff, p1_rz_ff;
   logic [LIN_BITS-1:0] p1_t1_ff;

   assign t1_full = (2*EW+1)'(c_cz) * (2*EW+1)'(sy) + (2*EW+1)'(c_cy);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_op_ff <= c_op;
         p1_ok_ff <= c_ok;
         p1_cx_ff <= c_cx;
         p1_ry_ff <= c_ry;
         p1_rz_ff <= c_r;
         p1_t1_ff <= LIN_BITS'(t1_full);
      end
   end

   // Second product: times size_x
   logic [LIN_BITS+EW-1:0] t2_full;
   logic                   p2_valid_ff, p2_op_ff, p2_ok_ff;
   logic [EW-1:0]          p2_cx_ff, p2_ry_ff, p2_rz_ff;
   logic [LIN_BITS-1:0]    p2_t2_ff;

   assign t2_full = (LIN_BITS+EW)'(p1_t1_ff) * (LIN_BITS+EW)'(sx);

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_op_ff <= p1_op_ff;
         p2_ok_ff <= p1_ok_ff;
         p2_cx_ff <= p1_cx_ff;
         p2_ry_ff <= p1_ry_ff;
         p2_rz_ff <= p1_rz_ff;
         p2_t2_ff <= LIN_BITS'(t2_full);
      end
   end

   // Output register: add x and select the result word
   logic                 rsp_valid_ff, res_ok_ff;
   logic [LIN_BITS-1:0]  lin_ff;
   logic [OUTC_BITS-1:0] ox_ff, oy_ff, oz_ff;
   logic [LIN_BITS-1:0]  lin_in;
   logic [OUTC_BITS-1:0] ox_in, oy_in, oz_in;
   logic                 res_ok_in;

   always_comb begin
      lin_in    = '0;
      ox_in     = '0;
      oy_in     = '0;
      oz_in     = '0;
      res_ok_in = 1'b1;
      if (p2_op_ff == OP_TO_COORD) begin
         ox_in = to_outc(p2_cx_ff);
         oy_in = to_outc(p2_ry_ff);
         oz_in = to_outc(p2_rz_ff);
      end else begin
         res_ok_in = p2_ok_ff;
         if (p2_ok_ff) begin
            lin_in = LIN_BITS'(p2_t2_ff + LIN_BITS'(p2_cx_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lin_ff    <= lin_in;
         ox_ff     <= ox_in;
         oy_ff     <= oy_in;
         oz_ff     <= oz_in;
         res_ok_ff <= res_ok_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_linear = lin_ff;
   assign rsp_out_x      = ox_ff;
   assign rsp_out_y      = oy_ff;
   assign rsp_out_z      = oz_ff;
   assign rsp_valid_res  = res_ok_ff;

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |->
         (rsp_out_linear == '0 && rsp_out_x == '0 && rsp_out_y == '0 &&
          rsp_out_z == '0))
      else $error("invalid word carries nonzero fields");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_linear == '0 ||
                     (rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0)))
      else $error("word mixes index and coordinate results");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stalled without a held output word");

   a_hold_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_linear)))
      else $error("held output word changed");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import pcmi_pkg::*;

   localparam int CB = DEF_COORD_BITS;
   localparam int SB = DEF_SIZE_BITS;
   localparam int LATENCY = 3 * 30 + 5;
   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic          opcode;
      logic [CB-1:0] x, y, z;
      logic [29:0]   lin;
   } word_type;

   typedef struct {
      logic [29:0] lin;
      logic [9:0]  x, y, z;
      logic        ok;
   } answer_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_opcode = 0;
   logic [CB-1:0] req_in_x = '0, req_in_y = '0, req_in_z = '0;
   logic [29:0] req_in_linear = '0;
   logic req_stall, rsp_valid, rsp_stall = 0, rsp_valid_res;
   logic [29:0] rsp_out_linear;
   logic [9:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic csr_valid = 0, csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   periodic_column_major_index_unit DUT (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // lattice geometry as the block should hold it
   logic [10:0] geo_size [3];
   logic [2:0]  geo_wrap;

   word_type   pending_words [$];
   answer_type expected_answers [$];
   int      failures = 0;
   bit      calm = 0;        // no idling in the closing part
   bit      hold_rsp = 0;    // request a long receiver hold-off
   int      hold_left = 0;
   int      idle_cycles = 0;

   function automatic longint extent(logic [10:0] s);
      if (s == 0) return 1;
      if (s > (1 << SB)) return 1 << SB;
      return s;
   endfunction

   function automatic answer_type predict_index(word_type w);
      answer_type a;
      longint sz [3];
      longint raw [3];
      longint c [3];
      longint r, acc;
      a = '{default: '0};
      for (int d = 0; d < 3; d++) sz[d] = extent(geo_size[d]);
      if (w.opcode == OP_TO_LINEAR) begin
         raw[0] = longint'($signed(w.x));
         raw[1] = longint'($signed(w.y));
         raw[2] = longint'($signed(w.z));
         a.ok = 1;
         for (int d = 0; d < 3; d++) begin
            if (raw[d] >= 0 && raw[d] < sz[d]) c[d] = raw[d];
            else if (geo_wrap[d]) begin
               r = raw[d] % sz[d];
               if (r < 0) r += sz[d];
               c[d] = r;
            end else begin
               c[d] = 0;
               a.ok = 0;
            end
         end
         if (a.ok) a.lin = 30'(c[0] + sz[0] * (c[1] + sz[1] * c[2]));
      end else begin
         acc = w.lin;
         for (int d = 0; d < 3; d++) begin
            c[d] = acc % sz[d];
            acc = acc / sz[d];
         end
         a.x = 10'(c[0]);
         a.y = 10'(c[1]);
         a.z = 10'(c[2]);
         a.ok = 1;
      end
      return a;
   endfunction

   // sampled handshake state from the rising edge
   int gap = 0;
   bit req_took;
   always @(posedge clock) begin
      req_took <= !reset && req_valid && !req_stall;
   end

   // driver: present words at the falling edge, idle in bursts
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_took) begin
            // hold the stalled word
         end else if (gap > 0) begin
            gap <= gap - 1;
            req_valid <= 0;
         end else if (pending_words.size() > 0) begin
            word_type w;
            if (!calm && $urandom_range(0, 15) == 0) begin
               gap <= $urandom_range(1, 18) - 1;
               req_valid <= 0;
            end else begin
               w = pending_words.pop_front();
               req_opcode <= w.opcode;
               req_in_x <= w.x;
               req_in_y <= w.y;
               req_in_z <= w.z;
               req_in_linear <= w.lin;
               req_valid <= 1;
               expected_answers.push_back(predict_index(w));
            end
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver idling in bursts, plus a long hold-off counted here
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else if (hold_rsp) begin
         hold_left <= LONG_HOLD - 1;
         hold_rsp <= 0;
         rsp_stall <= 1;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_stall <= 1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         rsp_gap <= $urandom_range(1, 18) - 1;
         rsp_stall <= 1;
      end else rsp_stall <= 0;
   end

   // monitor: compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected result lin=%0d", $time, rsp_out_linear);
            failures++;
         end else begin
            e = expected_answers.pop_front();
            if (rsp_out_linear !== e.lin || rsp_out_x !== e.x || rsp_out_y !== e.y ||
                rsp_out_z !== e.z || rsp_valid_res !== e.ok) begin
               $display("%0t: mismatch expected lin=%0d x=%0d y=%0d z=%0d ok=%0b",
                        $time, e.lin, e.x, e.y, e.z, e.ok);
               $display("%0t:          actual   lin=%0d x=%0d y=%0d z=%0d ok=%0b",
                        $time, rsp_out_linear, rsp_out_x, rsp_out_y, rsp_out_z,
                        rsp_valid_res);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("periodic_column_major_index_unit verification failed");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [10:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
      case (idx)
         CSR_SIZE_X:   geo_size[0] = val;
         CSR_SIZE_Y:   geo_size[1] = val;
         CSR_SIZE_Z:   geo_size[2] = val;
         CSR_PERIODIC: geo_wrap = val[2:0];
         default: ;
      endcase
   endtask

   task automatic drain_pipe();
      while (pending_words.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic set_geometry(logic [10:0] sx, logic [10:0] sy, logic [10:0] sz,
                               logic [2:0] wrap);
      drain_pipe();
      write_reg(CSR_SIZE_X, sx);
      write_reg(CSR_SIZE_Y, sy);
      write_reg(CSR_SIZE_Z, sz);
      write_reg(CSR_PERIODIC, wrap);
   endtask

   function automatic logic [CB-1:0] pick_coord(longint s);
      case ($urandom_range(0, 5))
         0: return CB'($urandom);
         1: return CB'(-longint'($urandom_range(1, 3 * s)));
         2: return CB'(s + $urandom_range(0, 3 * s));
         3: return $urandom_range(0, 1) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
         default: return CB'($urandom_range(0, s - 1));
      endcase
   endfunction

   task automatic queue_random(int n);
      word_type w;
      longint vol;
      vol = extent(geo_size[0]) * extent(geo_size[1]) * extent(geo_size[2]);
      repeat (n) begin
         w.opcode = 1'($urandom_range(0, 1));
         w.x = pick_coord(extent(geo_size[0]));
         w.y = pick_coord(extent(geo_size[1]));
         w.z = pick_coord(extent(geo_size[2]));
         if ($urandom_range(0, 3) == 0) w.lin = 30'($urandom);
         else w.lin = 30'($urandom_range(0, 32'(vol * 2 - 1)));
         pending_words.push_back(w);
      end
   endtask

   task automatic queue_word(logic op, int x, int y, int z, logic [29:0] lin);
      word_type w;
      w.opcode = op;
      w.x = CB'(x);
      w.y = CB'(y);
      w.z = CB'(z);
      w.lin = lin;
      pending_words.push_back(w);
   endtask

   initial begin
      geo_size = '{11'd1, 11'd1, 11'd1};
      geo_wrap = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: reset geometry, extremes, invalid and wrapped coordinates
      queue_word(OP_TO_LINEAR, 0, 0, 0, 0);
      queue_word(OP_TO_LINEAR, 1, 0, 0, 0);
      queue_word(OP_TO_COORD, 0, 0, 0, 30'h3fffffff);
      set_geometry(11'd0, 11'd2047, 11'd1024, 3'b000);
      queue_word(OP_TO_LINEAR, 0, 1023, 1023, 0);
      queue_word(OP_TO_LINEAR, 0, 1024, 0, 0);
      queue_word(OP_TO_LINEAR, -1, 0, 0, 0);
      queue_word(OP_TO_COORD, 0, 0, 0, 30'h3fffffff);
      queue_word(OP_TO_COORD, 0, 0, 0, 30'd1048577);
      set_geometry(11'd7, 11'd5, 11'd3, 3'b111);
      queue_word(OP_TO_LINEAR, -1048576, 1048575, -1, 0);
      queue_word(OP_TO_LINEAR, -7, 5, 3, 0);
      queue_word(OP_TO_LINEAR, 6, 4, 2, 0);
      queue_word(OP_TO_LINEAR, -8, -6, -4, 0);
      queue_word(OP_TO_COORD, -1, -1, -1, 30'd104);
      queue_word(OP_TO_COORD, 0, 0, 0, 30'd105);
      set_geometry(11'd1024, 11'd1024, 11'd1024, 3'b101);
      queue_word(OP_TO_LINEAR, 1023, 1023, 1023, 0);
      queue_word(OP_TO_LINEAR, 2000, 1023, -2000, 0);
      queue_word(OP_TO_LINEAR, 0, -1, 0, 0);
      queue_word(OP_TO_COORD, 0, 0, 0, 30'h3fffffff);

      // receiver holds off long while words keep coming
      set_geometry(11'd13, 11'd9, 11'd4, 3'b010);
      hold_rsp = 1;
      queue_random(200);
      wait (!hold_rsp);
      wait (hold_left == 0);

      // random phases over several geometries
      for (int p = 0; p < 7; p++) begin
         case (p)
            0: set_geometry(11'd1, 11'd1, 11'd1, 3'b000);
            1: set_geometry(11'd2047, 11'd1, 11'd3, 3'b011);
            2: set_geometry(11'($urandom_range(1, 64)), 11'($urandom_range(1, 64)),
                            11'($urandom_range(1, 64)), 3'($urandom));
            3: set_geometry(11'd1024, 11'd1024, 11'd1024, 3'b111);
            4: set_geometry(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                            11'($urandom_range(0, 2047)), 3'($urandom));
            5: set_geometry(11'd3, 11'd1000, 11'd0, 3'b100);
            default: begin
               set_geometry(11'($urandom_range(1, 40)), 11'($urandom_range(1, 40)),
                            11'($urandom_range(1, 40)), 3'($urandom));
               calm = 1;
            end
         endcase
         queue_random(130);
      end

      drain_pipe();
      if (failures == 0) $display("periodic_column_major_index_unit verification clean");
      else $display("periodic_column_major_index_unit verification failed");
      $finish;
   end

endmodule

### periodic_column_major_index_unit.f
rtl/pcmi_pkg.sv
rtl/pcmi_divmod.sv
rtl/periodic_column_major_index_unit.sv
tb/tb.sv
